@@ hdl/sha256_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, round constants and sigma functions for the streaming SHA-256 core.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LengthPos  = 56;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigestWords = 8;

  localparam logic [7:0] PadMark = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StFinal,
    StPad,
    StLen,
    StOut
  } sha_state_e;

  // Index 0 is H0.
  localparam logic [7:0][31:0] InitH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

@@ hdl/sha256_stream_hasher_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// Streaming SHA-256: one message byte per request, digest as eight words.
// ----------------------------------------------------------------------------
// A plain byte request is taken while the core is idle, so bytes can stream
// back to back, except that the request completing a 64-byte block holds the
// input while one shared round unit runs the 64 rounds at one round per
// cycle and StFinal then folds the result into the chaining words. A request
// with end_of_message runs the padding through the same byte path at one
// byte per cycle (0x80, zeros up to offset 56, eight length bytes), with a
// turn at offset 56 that moves no byte, plus one or two compressions, and
// then hands out the eight digest words through an output register at one
// word per cycle while the downstream side does not stall. The input stays
// stalled until the last digest word is loaded into that register.
module sha256_stream_hasher_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire sha256_pkg::sha_in_t in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output sha256_pkg::sha_out_t out_data_o
);

  localparam logic [5:0] FillLast  = 6'(sha256_pkg::BlockBytes - 1);
  localparam logic [5:0] FillLen   = 6'(sha256_pkg::LengthPos);
  localparam logic [5:0] RoundLast = 6'(sha256_pkg::Rounds - 1);
  localparam logic [2:0] WordLast  = 3'(sha256_pkg::DigestWords - 1);

  sha256_pkg::sha_state_e state_q, state_d;

  logic [5:0]        fill_q, fill_d;
  logic [63:0]       total_q, total_d;
  logic [7:0][31:0]  chain_q, chain_d;
  logic [7:0][31:0]  work_q, work_d;
  logic [511:0]      blk_q, blk_d;
  logic [63:0]       len_q, len_d;
  logic [5:0]        rnd_q, rnd_d;
  logic [2:0]        wcnt_q, wcnt_d;
  logic              fin_q, fin_d;
  logic              mark_q, mark_d;
  logic              len_done_q, len_done_d;
  logic              ovalid_q, ovalid_d;
  sha256_pkg::sha_out_t out_q, out_d;

  logic        accept;
  logic        push_en;
  logic [7:0]  push_byte;
  logic        block_full;
  logic        out_load;
  logic [63:0] total_inc;

  // Round datapath.
  logic [31:0] w_cur, w_new, t1, t2;
  logic [31:0] ra, rb, rc, rd, re, rf, rg, rh;

  assign accept     = in_valid_i && (state_q == sha256_pkg::StIdle);
  assign in_stall_o = (state_q != sha256_pkg::StIdle);
  assign total_inc  = total_q + 64'(in_data_i.has_byte);

  // Control outputs of the sequencer.
  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    out_load  = 1'b0;
    unique case (state_q)
      sha256_pkg::StIdle: begin
        push_en   = accept && in_data_i.has_byte;
        push_byte = in_data_i.data_byte;
      end
      sha256_pkg::StPad: begin
        push_en   = mark_q || (fill_q != FillLen);
        push_byte = mark_q ? sha256_pkg::PadMark : 8'h00;
      end
      sha256_pkg::StLen: begin
        push_en   = 1'b1;
        push_byte = len_q[63:56];
      end
      sha256_pkg::StOut: begin
        out_load = !ovalid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  assign block_full = push_en && (fill_q == FillLast);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha256_pkg::StIdle: begin
        if (accept) begin
          priority if (block_full)                 state_d = sha256_pkg::StRound;
          else if (in_data_i.end_of_message)       state_d = sha256_pkg::StPad;
          else                                     state_d = sha256_pkg::StIdle;
        end
      end
      sha256_pkg::StRound: begin
        if (rnd_q == RoundLast) state_d = sha256_pkg::StFinal;
      end
      sha256_pkg::StFinal: begin
        priority if (!fin_q)    state_d = sha256_pkg::StIdle;
        else if (len_done_q)    state_d = sha256_pkg::StOut;
        else                    state_d = sha256_pkg::StPad;
      end
      sha256_pkg::StPad: begin
        priority if (!push_en)  state_d = sha256_pkg::StLen;
        else if (block_full)    state_d = sha256_pkg::StRound;
        else                    state_d = sha256_pkg::StPad;
      end
      sha256_pkg::StLen: begin
        if (block_full) state_d = sha256_pkg::StRound;
      end
      sha256_pkg::StOut: begin
        if (out_load && (wcnt_q == WordLast)) state_d = sha256_pkg::StIdle;
      end
      default: state_d = sha256_pkg::StIdle;
    endcase
  end

  // One SHA-256 round and one schedule word per cycle.
  always_comb begin
    ra = work_q[0];
    rb = work_q[1];
    rc = work_q[2];
    rd = work_q[3];
    re = work_q[4];
    rf = work_q[5];
    rg = work_q[6];
    rh = work_q[7];
    w_cur = blk_q[511:480];
    t1 = rh + sha256_pkg::big_sigma1(re) + ((re & rf) ^ (~re & rg))
       + sha256_pkg::RoundK[rnd_q] + w_cur;
    t2 = sha256_pkg::big_sigma0(ra) + ((ra & rb) ^ (ra & rc) ^ (rb & rc));
    w_new = sha256_pkg::small_sigma1(blk_q[63:32]) + blk_q[223:192]
          + sha256_pkg::small_sigma0(blk_q[479:448]) + w_cur;
  end

  // Datapath next values.
  always_comb begin
    fill_d     = fill_q;
    total_d    = total_q;
    chain_d    = chain_q;
    work_d     = work_q;
    blk_d      = blk_q;
    len_d      = len_q;
    rnd_d      = '0;
    wcnt_d     = wcnt_q;
    fin_d      = fin_q;
    mark_d     = mark_q;
    len_done_d = len_done_q;
    ovalid_d   = ovalid_q;
    out_d      = out_q;

    if (push_en) begin
      blk_d  = {blk_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
    end
    if (block_full) begin
      work_d = chain_q;
    end

    if (accept) begin
      total_d = total_inc;
      if (in_data_i.end_of_message) begin
        fin_d   = 1'b1;
        mark_d  = 1'b1;
        len_d   = {total_inc[60:0], 3'b000};
        total_d = '0;
      end
    end

    unique case (state_q)
      sha256_pkg::StRound: begin
        work_d = {rg, rf, re, rd + t1, rc, rb, ra, t1 + t2};
        blk_d  = {blk_q[479:0], w_new};
        rnd_d  = rnd_q + 6'd1;
      end
      sha256_pkg::StFinal: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
      end
      sha256_pkg::StPad: begin
        if (push_en) begin
          mark_d = 1'b0;
        end else begin
          len_done_d = 1'b1;
        end
      end
      sha256_pkg::StLen: begin
        len_d = {len_q[55:0], 8'h00};
      end
      default: begin
      end
    endcase

    // Drop the word once taken, then refill while the digest drains.
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (out_load) begin
      ovalid_d            = 1'b1;
      out_d.digest_word   = chain_q[wcnt_q];
      out_d.word_index    = wcnt_q;
      out_d.last_word     = (wcnt_q == WordLast);
      wcnt_d              = wcnt_q + 3'd1;
      if (wcnt_q == WordLast) begin
        chain_d    = sha256_pkg::InitH;
        fin_d      = 1'b0;
        len_done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha256_pkg::StIdle;
      fill_q     <= '0;
      total_q    <= '0;
      chain_q    <= sha256_pkg::InitH;
      rnd_q      <= '0;
      wcnt_q     <= '0;
      fin_q      <= 1'b0;
      mark_q     <= 1'b0;
      len_done_q <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      total_q    <= total_d;
      chain_q    <= chain_d;
      rnd_q      <= rnd_d;
      wcnt_q     <= wcnt_d;
      fin_q      <= fin_d;
      mark_q     <= mark_d;
      len_done_q <= len_done_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    blk_q  <= blk_d;
    len_q  <= len_d;
    out_q  <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  // Rounds only start on a complete block.
  a_round_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256_pkg::StRound) |-> (fill_q == '0))
    else $error("round unit running on a partial block");

  a_round_starts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == sha256_pkg::StRound) && ($past(state_q) != sha256_pkg::StRound))
      |-> (rnd_q == '0))
    else $error("round counter not cleared at block start");

  a_len_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256_pkg::StLen) |-> (fill_q >= FillLen))
    else $error("length bytes placed before offset 56");

  a_idle_no_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256_pkg::StIdle) |-> (!fin_q && !len_done_q))
    else $error("finish flags left set in idle");

  a_digest_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == sha256_pkg::StOut))
    else $error("digest word issued outside the output phase");

endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming SHA-256 core. A table of directed
// requests (empty message, "abc", byte extremes, end with and without a byte)
// runs first, then random messages whose lengths favor the padding edges
// around 55/56 and 64 bytes. Both sides idle at random, and one long
// downstream hold backs the core up into its input. Every digest word is
// checked against a bench-side SHA-256 model or a known digest.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RandomItems  = 400;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned TailCycles   = 200;
  localparam int unsigned PressureAt   = 64;
  localparam int unsigned PressureHold = 400;
  localparam int unsigned NumRows      = 12;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam int unsigned LenSlot  = 56;

  localparam logic [255:0] EmptyDigest =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Message lengths around the padding and block boundaries.
  localparam int unsigned EdgeLen [12] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 128};

  typedef struct packed {
    logic         fixed;
    logic [255:0] digest;
  } digest_tag_t;

  typedef struct packed {
    sha256_pkg::sha_in_t req;
    digest_tag_t         tag;
  } stim_row_t;

  // Known digests only after reset; other rows go through the model.
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{'{8'hff, 1'b0, 1'b0}, '{1'b0, 256'h0}},        // neither byte nor end
    '{'{8'h5a, 1'b0, 1'b1}, '{1'b1, EmptyDigest}},   // end of an empty message
    '{'{8'h61, 1'b1, 1'b0}, '{1'b0, 256'h0}},
    '{'{8'h62, 1'b1, 1'b0}, '{1'b0, 256'h0}},
    '{'{8'h63, 1'b1, 1'b1}, '{1'b1, AbcDigest}},
    '{'{8'h00, 1'b0, 1'b0}, '{1'b0, 256'h0}},
    '{'{8'hff, 1'b1, 1'b0}, '{1'b0, 256'h0}},
    '{'{8'h00, 1'b1, 1'b0}, '{1'b0, 256'h0}},
    '{'{8'hff, 1'b1, 1'b1}, '{1'b0, 256'h0}},
    '{'{8'ha5, 1'b1, 1'b0}, '{1'b0, 256'h0}},
    '{'{8'hff, 1'b0, 1'b1}, '{1'b0, 256'h0}},        // end without a byte
    '{'{8'h00, 1'b1, 1'b1}, '{1'b0, 256'h0}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  wire                  in_stall;
  sha256_pkg::sha_in_t  in_data = '0;
  wire                  out_valid;
  logic                 out_stall = 1'b0;
  sha256_pkg::sha_out_t out_data;

  sha256_stream_hasher_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bench-side hash state.
  logic [31:0] chain_h [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill;
  logic [63:0] msg_bytes;

  sha256_pkg::sha_out_t expected_words_q [$];
  digest_tag_t          request_tag_q [$];
  int unsigned          errors = 0;
  int unsigned          quiet_cycles = 0;
  bit                   sender_calm = 1'b0;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = HashInit[i];
    block_fill = 0;
    msg_bytes  = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2, x, y;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = w[i-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[i-7] +
             (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
    end
    for (int i = 0; i < 8; i++) r[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25)) +
           ((r[4] & r[5]) ^ (~r[4] & r[6])) + RoundConst[i] + w[i];
      t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22)) +
           ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6];
      r[6] = r[5];
      r[5] = r[4];
      r[4] = r[3] + t1;
      r[3] = r[2];
      r[2] = r[1];
      r[1] = r[0];
      r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + r[i];
  endtask

  task automatic load_byte(input logic [7:0] b);
    block_bytes[block_fill] = b;
    block_fill = (block_fill + 1) % 64;
    if (block_fill == 0) compress_block();
  endtask

  // Take one request; on end of message, pad and queue the eight digest words.
  task automatic absorb_request(input sha256_pkg::sha_in_t req, input digest_tag_t tag);
    logic [63:0]          bit_len;
    sha256_pkg::sha_out_t word;
    if (req.has_byte) begin
      load_byte(req.data_byte);
      msg_bytes = msg_bytes + 64'd1;
    end
    if (req.end_of_message) begin
      bit_len = msg_bytes << 3;
      load_byte(PadByte);
      while (block_fill != LenSlot) load_byte(8'h00);
      for (int i = 0; i < 8; i++) load_byte(bit_len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        word.digest_word = tag.fixed ? tag.digest[255-32*i -: 32] : chain_h[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 7);
        expected_words_q.push_back(word);
      end
      restart_hash();
    end
  endtask

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(input sha256_pkg::sha_in_t req, input digest_tag_t tag);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_tag_q.push_back(tag);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    sha256_pkg::sha_out_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        absorb_request(in_data, request_tag_q.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (expected_words_q.size() == 0) begin
          $display("%0t: unexpected digest word, expected none, got %h index %0d last %0b",
                   $time, out_data.digest_word, out_data.word_index, out_data.last_word);
          errors <= errors + 1;
        end else begin
          want = expected_words_q.pop_front();
          if (out_data.digest_word !== want.digest_word ||
              out_data.word_index !== want.word_index ||
              out_data.last_word !== want.last_word) begin
            $display("%0t: digest word mismatch, expected %h index %0d last %0b, got %h index %0d last %0b",
                     $time, want.digest_word, want.word_index, want.last_word,
                     out_data.digest_word, out_data.word_index, out_data.last_word);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // Downstream side: random stalls, calm stretches and one long hold.
  initial begin
    int unsigned hold;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 8 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == PressureAt) hold = PressureHold;
      else hold = calm ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    sha256_pkg::sha_in_t req;
    digest_tag_t         no_tag;
    int unsigned         sent;
    int unsigned         len;
    bit                  split_end;
    no_tag = '0;
    sent   = 0;
    restart_hash();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      send_request(DirectedRows[i].req, DirectedRows[i].tag);
    end

    while (sent < RandomItems) begin
      if ($urandom_range(0, 2) == 0) len = EdgeLen[$urandom_range(0, 11)];
      else len = $urandom_range(0, 20);
      sender_calm = ($urandom_range(0, 3) == 0);
      split_end   = (len == 0) || ($urandom_range(0, 1) == 1);
      for (int k = 0; k < len; k++) begin
        // Drop in an idle request now and then; it must leave the hash alone.
        if ($urandom_range(0, 7) == 0) begin
          req = '{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0, end_of_message: 1'b0};
          send_request(req, no_tag);
        end
        req.data_byte      = 8'($urandom_range(0, 255));
        req.has_byte       = 1'b1;
        req.end_of_message = !split_end && (k == len - 1);
        send_request(req, no_tag);
        sent++;
      end
      if (split_end) begin
        req = '{data_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0, end_of_message: 1'b1};
        send_request(req, no_tag);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Let the monitor take in the last request before draining.
    @(posedge clk);
    while (expected_words_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
